// ===== hdl/isdbm_pkg.sv =====
// ----------------------------------------------------------------------------
// isdbm_pkg
// Shared types and constants for the icon size and depth best match block.
// ----------------------------------------------------------------------------
package isdbm_pkg;

   // widths fixed by the entry and register formats
   localparam int EDGE_W   = 9;    // 1..256 pixels
   localparam int REQ_W    = 11;   // requested edge
   localparam int DISP_W   = 8;    // display depth
   localparam int AREA_W   = 17;   // up to 256 * 256
   localparam int DEPTH_W  = 17;   // up to 256 * 256
   localparam int DIST_W   = 12;   // sum of two 11 bit distances
   localparam int INDEX_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [REQ_W-1:0]  REQ_WIDTH_RESET     = 11'd32;
   localparam logic [REQ_W-1:0]  REQ_HEIGHT_RESET    = 11'd32;
   localparam logic [DISP_W-1:0] DISPLAY_DEPTH_RESET = 8'd32;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_DEPTH = 2'd2;

   // size classes, lower is better
   typedef enum logic [1:0] {
      KIND_EXACT  = 2'd0,
      KIND_INSIDE = 2'd1,
      KIND_COVERS = 2'd2,
      KIND_OTHER  = 2'd3
   } kind_type;

   // one classified entry, as it travels from front to back
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               compare;   // entry lies within the directory limit
      logic               last;
      kind_type           kind;
      logic [EDGE_W-1:0]  width;
      logic [EDGE_W-1:0]  height;
      logic [AREA_W-1:0]  area;
      logic [DIST_W-1:0]  distance;
      logic [DEPTH_W-1:0] depth;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== hdl/isdbm_front.sv =====
// ----------------------------------------------------------------------------
// isdbm_front
// Takes directory entries, decodes edges and depth, classes the size and
// numbers the entry within its directory.
// ----------------------------------------------------------------------------
module isdbm_front #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [7:0]                       width_byte,
   input  logic [7:0]                       height_byte,
   input  logic [15:0]                      plane_count,
   input  logic [15:0]                      bit_count,
   input  logic                             last_entry,
   input  logic [isdbm_pkg::REQ_W-1:0]      req_width,
   input  logic [isdbm_pkg::REQ_W-1:0]      req_height,
   output isdbm_pkg::entry_type             entry
);
   import isdbm_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 in_range;
   logic [EDGE_W-1:0]    w;
   logic [EDGE_W-1:0]    h;
   logic [REQ_W-1:0]     w_ext;
   logic [REQ_W-1:0]     h_ext;
   logic [REQ_W-1:0]     dist_w;
   logic [REQ_W-1:0]     dist_h;
   logic [2*EDGE_W-1:0]  area_full;
   logic [2*EDGE_W-1:0]  depth_full;
   logic                 depth_ok;
   kind_type             kind;

   assign in_range = count_ff < CNT_W'(MAX_ENTRIES);

   // zero byte encodes 256
   assign w = (width_byte == 8'd0)  ? 9'd256 : {1'b0, width_byte};
   assign h = (height_byte == 8'd0) ? 9'd256 : {1'b0, height_byte};
   assign w_ext = REQ_W'(w);
   assign h_ext = REQ_W'(h);

   assign depth_ok = (plane_count != 16'd0) && (bit_count != 16'd0) &&
                     (plane_count <= 16'd256) && (bit_count <= 16'd256);
   assign depth_full = plane_count[EDGE_W-1:0] * bit_count[EDGE_W-1:0];
   assign area_full  = w * h;

   assign dist_w = (w_ext > req_width)  ? w_ext - req_width  : req_width - w_ext;
   assign dist_h = (h_ext > req_height) ? h_ext - req_height : req_height - h_ext;

   always_comb begin
      if (w_ext == req_width && h_ext == req_height) begin
         kind = KIND_EXACT;
      end else if (w_ext <= req_width && h_ext <= req_height) begin
         kind = KIND_INSIDE;
      end else if (w_ext >= req_width && h_ext >= req_height) begin
         kind = KIND_COVERS;
      end else begin
         kind = KIND_OTHER;
      end
   end

   always_comb begin
      entry.index    = INDEX_W'(count_ff);
      entry.compare  = in_range;
      entry.last     = last_entry;
      entry.kind     = kind;
      entry.width    = w;
      entry.height   = h;
      entry.area     = area_full[AREA_W-1:0];
      entry.distance = DIST_W'(dist_w) + DIST_W'(dist_h);
      entry.depth    = depth_ok ? depth_full[DEPTH_W-1:0] : '0;
   end

   // counter saturates at the limit and restarts after the last entry
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (last_entry) begin
            count_in = '0;
         end else if (in_range) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/isdbm_queue.sv =====
// ----------------------------------------------------------------------------
// isdbm_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module isdbm_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  isdbm_pkg::entry_type         push_entry,
   input  logic                         pop,
   output isdbm_pkg::entry_type         head,
   output isdbm_pkg::queue_status_type  status
);
   import isdbm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/isdbm_back.sv =====
// ----------------------------------------------------------------------------
// isdbm_back
// Compares each classified entry against the held best one and presents the
// chosen index at the end of a directory.
// ----------------------------------------------------------------------------
module isdbm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  isdbm_pkg::entry_type              head,
   input  isdbm_pkg::queue_status_type       status,
   input  logic [isdbm_pkg::DISP_W-1:0]      display_depth,
   input  logic                              rsp_stall,
   output logic                              pop,
   output logic                              rsp_valid,
   output logic [isdbm_pkg::INDEX_W-1:0]     rsp_best_index
);
   import isdbm_pkg::*;

   logic                have_best_ff;
   logic                have_best_in;
   logic [INDEX_W-1:0]  held_index_ff;
   kind_type            held_class_ff;
   logic [EDGE_W-1:0]   held_width_ff;
   logic [EDGE_W-1:0]   held_height_ff;
   logic [AREA_W-1:0]   held_area_ff;
   logic [DIST_W-1:0]   held_dist_ff;
   logic [DEPTH_W-1:0]  held_depth_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [INDEX_W-1:0]  rsp_index_in;
   logic                same_class;
   logic                size_wins;
   logic                size_ties;
   logic                update;

   function automatic logic depth_preferred(input logic [DEPTH_W-1:0] cand,
                                            input logic [DEPTH_W-1:0] best,
                                            input logic [DISP_W-1:0]  disp);
      logic [DEPTH_W-1:0] d;
      logic               r;
      d = DEPTH_W'(disp);
      if (cand == '0) begin
         r = 1'b0;
      end else if (best == '0) begin
         r = 1'b1;
      end else if (cand == d) begin
         r = (best != d);
      end else if (best == d) begin
         r = 1'b0;
      end else if (cand < d) begin
         r = (best > d) || (cand > best);
      end else if (best < d) begin
         r = 1'b0;
      end else begin
         r = (cand < best);
      end
      return r;
   endfunction

   // a last entry needs the result register free, others never wait
   assign pop = !status.empty && (!head.last || !rsp_valid_ff || !rsp_stall);

   assign same_class = (head.kind == held_class_ff);

   always_comb begin
      size_wins = !have_best_ff || (head.kind < held_class_ff);
      if (have_best_ff && same_class) begin
         case (head.kind)
            KIND_INSIDE: size_wins = head.area > held_area_ff;
            KIND_COVERS: size_wins = head.area < held_area_ff;
            KIND_OTHER:  size_wins = head.distance < held_dist_ff;
            default:     size_wins = 1'b0;
         endcase
      end
   end

   assign size_ties = have_best_ff && same_class &&
                      (head.width == held_width_ff) && (head.height == held_height_ff);

   assign update = pop && head.compare &&
                   (size_wins ||
                    (size_ties && depth_preferred(head.depth, held_depth_ff, display_depth)));

   always_comb begin
      have_best_in = have_best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      if (update) begin
         have_best_in = 1'b1;
      end
      if (pop && head.last) begin
         have_best_in = 1'b0;
         rsp_valid_in = 1'b1;
         if (update) begin
            rsp_index_in = head.index;
         end else if (have_best_ff) begin
            rsp_index_in = held_index_ff;
         end else begin
            rsp_index_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         held_index_ff  <= head.index;
         held_class_ff  <= head.kind;
         held_width_ff  <= head.width;
         held_height_ff <= head.height;
         held_area_ff   <= head.area;
         held_dist_ff   <= head.distance;
         held_depth_ff  <= head.depth;
      end
      rsp_index_ff <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_index = rsp_index_ff;

endmodule

// ===== hdl/icon_size_depth_best_match.sv =====
// ----------------------------------------------------------------------------
// icon_size_depth_best_match
// Picks the best icon directory entry for a requested size and display depth.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  width, height, planes, bits, last
//   rsp      out        rsp_valid / rsp_stall  best_index
//   csr      in         csr_write_en           csr_index, csr_write_data
//
// One entry per cycle sustained unless a stalled result holds a last entry.
// An entry is classified in the cycle it is taken, waits in a two-deep queue,
// and is compared against the held best entry in the cycle it leaves the
// queue; the result register is loaded there and drives best_index. A
// stalled result holds back only last entries; at most one further entry
// is taken before req_stall rises. Reset is synchronous and clears the
// queue, the entry count and the held best.
// ----------------------------------------------------------------------------
module icon_size_depth_best_match #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_width_byte,
   input  logic [7:0]                           req_height_byte,
   input  logic [15:0]                          req_plane_count,
   input  logic [15:0]                          req_bit_count,
   input  logic                                 req_last_entry,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [isdbm_pkg::INDEX_W-1:0]        rsp_best_index,
   input  logic                                 csr_write_en,
   input  logic [isdbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [isdbm_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import isdbm_pkg::*;

   logic [REQ_W-1:0]   req_width_ff;
   logic [REQ_W-1:0]   req_height_ff;
   logic [DISP_W-1:0]  display_depth_ff;
   logic               req_accept;
   logic               pop;
   entry_type          front_entry;
   entry_type          head;
   queue_status_type   status;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_width_ff     <= REQ_WIDTH_RESET;
         req_height_ff    <= REQ_HEIGHT_RESET;
         display_depth_ff <= DISPLAY_DEPTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_REQ_WIDTH:     req_width_ff     <= csr_write_data[REQ_W-1:0];
            CSR_REQ_HEIGHT:    req_height_ff    <= csr_write_data[REQ_W-1:0];
            CSR_DISPLAY_DEPTH: display_depth_ff <= csr_write_data[DISP_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall  = status.full;
   assign req_accept = req_valid && !req_stall;

   isdbm_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .width_byte  (req_width_byte),
      .height_byte (req_height_byte),
      .plane_count (req_plane_count),
      .bit_count   (req_bit_count),
      .last_entry  (req_last_entry),
      .req_width   (req_width_ff),
      .req_height  (req_height_ff),
      .entry       (front_entry)
   );

   isdbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   isdbm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .status         (status),
      .display_depth  (display_depth_ff),
      .rsp_stall      (rsp_stall),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_best_index (rsp_best_index)
   );

   // queue cannot be full and empty at once
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(status.full && status.empty))
      else $error("queue reports full and empty");

   // back never takes from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   // a result only starts after a last entry left the queue
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop && head.last))
      else $error("result without last entry");

   // a waiting result is never replaced by a later last entry
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(pop && head.last))
      else $error("last entry popped over a stalled result");

endmodule
